FILE: sv/ble_ll_pdu_classifier_macros.svh
// Assertion macros used by the classifier back end.
`ifndef BLE_LL_PDU_CLASSIFIER_MACROS_SVH
`define BLE_LL_PDU_CLASSIFIER_MACROS_SVH

// Same-cycle implication on clk_i, disabled while rst_ni is low.
`define BPC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle property violated");

// Next-cycle implication on clk_i, disabled while rst_ni is low.
`define BPC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle property violated");

`endif

FILE: sv/bpc_pkg.sv
// Types and constants for the link-layer PDU header classifier.
`timescale 1ns / 1ps
package bpc_pkg;

  localparam int unsigned CntW        = 32;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [7:0] HdrLen       = 8'd2;
  localparam logic [7:0] LenMask      = 8'h3F;
  localparam logic [7:0] TypeMask     = 8'h0F;
  localparam logic [7:0] LlidMask     = 8'h03;
  localparam logic [7:0] AdvChLo      = 8'd37;
  localparam logic [7:0] AdvChHi      = 8'd39;
  localparam logic [7:0] DataChHi     = 8'd36;
  localparam logic [7:0] TypeNone     = 8'hFF;

  localparam logic [3:0] FlagAdvCh    = 4'b0001;
  localparam logic [3:0] FlagExt      = 4'b0010;
  localparam logic [3:0] FlagDataCh   = 4'b0100;
  localparam logic [3:0] FlagRsvd     = 4'b1000;

  localparam logic       OpClassify   = 1'b0;

  typedef enum logic [2:0] {
    PK_UNKNOWN = 3'd0,
    PK_ADV     = 3'd1,
    PK_SCAN    = 3'd2,
    PK_CONNECT = 3'd3,
    PK_DATA    = 3'd4
  } kind_e;

  // What the back end does with a queued entry.
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PASS  = 2'd1,
    CMD_DROP  = 2'd2,
    CMD_COUNT = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    kind_e      kind;
    logic [7:0] type_code;
    logic [3:0] flags;
    logic [7:0] kept;
  } pkt_t;

endpackage

FILE: sv/bpc_front.sv
// Front end: mode register and header decode into a queue entry.
`timescale 1ns / 1ps
module bpc_front
  import bpc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       operation_i,
  input  logic [7:0] channel_i,
  input  logic [7:0] packet_length_i,
  input  logic [7:0] header_first_i,
  input  logic [7:0] header_second_i,
  output pkt_t       pkt_o
);

  logic       ble_mode_q, ble_mode_d;
  logic [7:0] expect_len;
  logic [7:0] adv_type;
  logic [7:0] llid;

  assign ble_mode_d = cfg_we_i ? cfg_wdata_i : ble_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ble_mode_q <= 1'b0;
    end else begin
      ble_mode_q <= ble_mode_d;
    end
  end

  assign expect_len = HdrLen + (header_second_i & LenMask);
  assign adv_type   = header_first_i & TypeMask;
  assign llid       = header_first_i & LlidMask;

  always_comb begin
    pkt_o.cmd       = CMD_PASS;
    pkt_o.kind      = PK_UNKNOWN;
    pkt_o.type_code = TypeNone;
    pkt_o.flags     = 4'b0000;
    pkt_o.kept      = packet_length_i;
    if (operation_i != OpClassify) begin
      pkt_o.cmd  = CMD_CLEAR;
      pkt_o.kept = 8'd0;
    end else if (ble_mode_q) begin
      if (packet_length_i < HdrLen || expect_len > packet_length_i) begin
        pkt_o.cmd = CMD_DROP;
      end else begin
        pkt_o.cmd  = CMD_COUNT;
        pkt_o.kept = expect_len;
        if (channel_i inside {[AdvChLo:AdvChHi]}) begin
          pkt_o.type_code = adv_type;
          pkt_o.flags     = FlagAdvCh;
          case (adv_type[3:0])
            4'd3, 4'd4: begin
              pkt_o.kind = PK_SCAN;
            end
            4'd5: begin
              pkt_o.kind = PK_CONNECT;
            end
            4'd0, 4'd1, 4'd2, 4'd6: begin
              pkt_o.kind = PK_ADV;
            end
            4'd7: begin
              pkt_o.kind  = PK_ADV;
              pkt_o.flags = FlagAdvCh | FlagExt;
            end
            default: begin
              pkt_o.flags = FlagAdvCh | FlagRsvd;
            end
          endcase
        end else if (channel_i <= DataChHi) begin
          pkt_o.type_code = llid;
          if (llid == 8'd0) begin
            pkt_o.flags = FlagDataCh | FlagRsvd;
          end else begin
            pkt_o.kind  = PK_DATA;
            pkt_o.flags = FlagDataCh;
          end
        end
      end
    end
  end

endmodule

FILE: sv/bpc_fifo.sv
// Small queue of decoded entries between front and back end.
`timescale 1ns / 1ps
module bpc_fifo
  import bpc_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pkt_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output pkt_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWq = $clog2(Depth + 1);

  pkt_t             mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntWq-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntWq'(Depth));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntWq'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntWq'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload storage, no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: sv/bpc_back.sv
// Back end: counter updates and the registered result.
`timescale 1ns / 1ps
module bpc_back
  import bpc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  pkt_t            q_pkt_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            accepted_o,
  output logic [2:0]      pdu_kind_o,
  output logic [7:0]      pdu_type_o,
  output logic [3:0]      pdu_flags_o,
  output logic [7:0]      kept_length_o,
  output logic [CntW-1:0] dropped_total_o,
  output logic [CntW-1:0] unknown_total_o,
  output logic [CntW-1:0] adv_total_o,
  output logic [CntW-1:0] scan_total_o,
  output logic [CntW-1:0] connect_total_o,
  output logic [CntW-1:0] data_total_o
);

  logic              out_valid_q, out_valid_d;
  pkt_t              res_q;
  logic              pop;
  logic [CntW-1:0]   dropped_q, dropped_d;
  logic [CntW-1:0]   unknown_q, unknown_d;
  logic [CntW-1:0]   adv_q, adv_d;
  logic [CntW-1:0]   scan_q, scan_d;
  logic [CntW-1:0]   connect_q, connect_d;
  logic [CntW-1:0]   data_q, data_d;
  logic              clear_pop, drop_pop, pass_pop;
  logic [6*CntW-1:0] totals;

  // Take the next entry when the result slot is empty or being drained.
  assign pop     = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = pop;

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    dropped_d = dropped_q;
    unknown_d = unknown_q;
    adv_d     = adv_q;
    scan_d    = scan_q;
    connect_d = connect_q;
    data_d    = data_q;
    if (pop) begin
      case (q_pkt_i.cmd)
        CMD_CLEAR: begin
          unknown_d = '0;
          adv_d     = '0;
          scan_d    = '0;
          connect_d = '0;
          data_d    = '0;
        end
        CMD_DROP: begin
          dropped_d = dropped_q + CntW'(1);
        end
        CMD_COUNT: begin
          case (q_pkt_i.kind)
            PK_ADV:     adv_d     = adv_q + CntW'(1);
            PK_SCAN:    scan_d    = scan_q + CntW'(1);
            PK_CONNECT: connect_d = connect_q + CntW'(1);
            PK_DATA:    data_d    = data_q + CntW'(1);
            default:    unknown_d = unknown_q + CntW'(1);
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      dropped_q   <= '0;
      unknown_q   <= '0;
      adv_q       <= '0;
      scan_q      <= '0;
      connect_q   <= '0;
      data_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      dropped_q   <= dropped_d;
      unknown_q   <= unknown_d;
      adv_q       <= adv_d;
      scan_q      <= scan_d;
      connect_q   <= connect_d;
      data_q      <= data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= q_pkt_i;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = (res_q.cmd == CMD_PASS) || (res_q.cmd == CMD_COUNT);
  assign pdu_kind_o      = res_q.kind;
  assign pdu_type_o      = res_q.type_code;
  assign pdu_flags_o     = res_q.flags;
  assign kept_length_o   = res_q.kept;
  assign dropped_total_o = dropped_q;
  assign unknown_total_o = unknown_q;
  assign adv_total_o     = adv_q;
  assign scan_total_o    = scan_q;
  assign connect_total_o = connect_q;
  assign data_total_o    = data_q;

  assign clear_pop = pop && (q_pkt_i.cmd == CMD_CLEAR);
  assign drop_pop  = pop && (q_pkt_i.cmd == CMD_DROP);
  assign pass_pop  = pop && (q_pkt_i.cmd == CMD_PASS);
  assign totals    = {dropped_q, unknown_q, adv_q, scan_q, connect_q, data_q};

`include "ble_ll_pdu_classifier_macros.svh"

  `BPC_ASSERT_NXT(a_stall_holds_totals, out_valid_q && !out_ready_i, $stable(totals))
  `BPC_ASSERT_NXT(a_clear_zeroes, clear_pop, unknown_q == '0 && data_q == '0 && $stable(dropped_q))
  `BPC_ASSERT_NXT(a_drop_counts, drop_pop, dropped_q == $past(dropped_q) + CntW'(1))
  `BPC_ASSERT_NXT(a_pass_still, pass_pop, $stable(totals))
  `BPC_ASSERT_IMP(a_pop_has_room, pop, !out_valid_q || out_ready_i)

endmodule

FILE: sv/ble_ll_pdu_classifier.sv
// Top level of the link-layer PDU header classifier.
//
//   channel   signals                            direction
//   -------   --------------------------------   ---------
//   config    cfg_we_i, cfg_wdata_i              in, no stall
//   packet    in_valid_i / in_ready_o + fields   in
//   result    out_valid_o / out_ready_i + fields out
//
// One transfer per cycle unless the result stalls; a packet taken at the input is
// written into the queue, then into the result slot as the back takes it, and
// shows from then on. The front decodes combinationally into a QDepth-entry queue;
// the back updates the counters as it takes an entry, so totals hold while a result
// stalls. in_ready_o drops only when the queue is full behind a stalled result.
// Reset (async, active low) clears the mode to pass-through, counters and queue.
`timescale 1ns / 1ps
module ble_ll_pdu_classifier
  import bpc_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            operation_i,
  input  logic [7:0]      channel_i,
  input  logic [7:0]      packet_length_i,
  input  logic [7:0]      header_first_i,
  input  logic [7:0]      header_second_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            accepted_o,
  output logic [2:0]      pdu_kind_o,
  output logic [7:0]      pdu_type_o,
  output logic [3:0]      pdu_flags_o,
  output logic [7:0]      kept_length_o,
  output logic [CntW-1:0] dropped_total_o,
  output logic [CntW-1:0] unknown_total_o,
  output logic [CntW-1:0] adv_total_o,
  output logic [CntW-1:0] scan_total_o,
  output logic [CntW-1:0] connect_total_o,
  output logic [CntW-1:0] data_total_o
);

  pkt_t front_pkt;
  pkt_t q_pkt;
  logic q_full;
  logic q_valid;
  logic q_pop;

  // Decode the header and hold the mode register.
  bpc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .operation_i     (operation_i),
    .channel_i       (channel_i),
    .packet_length_i (packet_length_i),
    .header_first_i  (header_first_i),
    .header_second_i (header_second_i),
    .pkt_o           (front_pkt)
  );

  // Accept a packet whenever the queue has room.
  assign in_ready_o = !q_full;

  bpc_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .wdata_i (front_pkt),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_pkt)
  );

  // Advance counters and present the result.
  bpc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_pkt_i         (q_pkt),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .accepted_o      (accepted_o),
    .pdu_kind_o      (pdu_kind_o),
    .pdu_type_o      (pdu_type_o),
    .pdu_flags_o     (pdu_flags_o),
    .kept_length_o   (kept_length_o),
    .dropped_total_o (dropped_total_o),
    .unknown_total_o (unknown_total_o),
    .adv_total_o     (adv_total_o),
    .scan_total_o    (scan_total_o),
    .connect_total_o (connect_total_o),
    .data_total_o    (data_total_o)
  );

endmodule
